[hdl/vsrot_pkg.sv]
// Shared constants, widths and the CORDIC arctangent table for the vertex set rotator.
`default_nettype none

package vsrot_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CORDIC_STEPS = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int NSTEPS       = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(NSTEPS);

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    localparam int VTX_W  = 25;
    localparam int CS_W   = VTX_W + 1;
    localparam int DX_W   = VTX_W + 2;
    localparam int TRIG_W = 32;
    localparam int PROD_W = DX_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int FRAC_W = 30;
    localparam int ANG_W  = 16;

    localparam logic signed [VTX_W-1:0]  BOX_START_MIN = 25'sd16776960;
    localparam logic signed [VTX_W-1:0]  BOX_START_MAX = 25'sd0;
    localparam logic signed [VTX_W-1:0]  COORD_MAX     = 25'sd16777215;
    localparam logic signed [VTX_W-1:0]  COORD_MIN     = -25'sd16777216;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN   = 32'sd652032874;

    // Arctangent of 2^-i in phase units, one turn = 2^32.
    function automatic logic signed [TRIG_W-1:0] atan_phase(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933405;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335086;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41721;
            5'd15:   v = 32'sd20860;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2607;
            5'd19:   v = 32'sd1303;
            5'd20:   v = 32'sd651;
            5'd21:   v = 32'sd325;
            5'd22:   v = 32'sd162;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/vsrot_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vsrot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/vertex_set_rotate_about_center.sv]
// Loading: one item per cycle, busy stays low; the last-marked item starts the rotation.
// Rotation: the shared CORDIC stage iterates over its steps, then one setup step, then for
// each stored vertex: difference, four products on the one multiplier, emit.
// Results are strobed for one cycle each and cannot be stalled by the receiver.
// Synchronous active-low reset clears the set, the box and the angle register.
`default_nettype none

module vertex_set_rotate_about_center
    import vsrot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VTX_W-1:0] i_vertex_x,
    input  logic signed [VTX_W-1:0] i_vertex_y,
    input  logic                    i_last_vertex,
    input  logic                    i_cfg_we,
    input  logic [ANG_W-1:0]        i_cfg_wdata,
    output logic                    o_strobe,
    output logic signed [VTX_W-1:0] o_rotated_x,
    output logic signed [VTX_W-1:0] o_rotated_y,
    output logic                    o_end_of_set,
    output logic                    o_dropped_flag
);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_CORDIC = 6'b000010,
        S_SETUP  = 6'b000100,
        S_DIFF   = 6'b001000,
        S_MUL    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    localparam logic [2:0] MUL_LAST = 3'd4;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_overflow, n_overflow;
    logic signed [VTX_W-1:0]  r_min_x, n_min_x, r_min_y, n_min_y;
    logic signed [VTX_W-1:0]  r_max_x, n_max_x, r_max_y, n_max_y;
    logic [ANG_W-1:0]         r_angle, n_angle;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [2:0]               r_k, n_k;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_strobe, n_strobe;

    logic signed [TRIG_W-1:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic                     r_neg, n_neg;
    logic signed [TRIG_W-1:0] r_cos, n_cos, r_sin, n_sin;
    logic signed [CS_W-1:0]   r_csx, n_csx, r_csy, n_csy;
    logic signed [ACC_W-1:0]  r_biasx, n_biasx, r_biasy, n_biasy;
    logic signed [DX_W-1:0]   r_dx, n_dx, r_dy, n_dy;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_accx, n_accx, r_accy, n_accy;
    logic signed [VTX_W-1:0]  r_rx, n_rx, r_ry, n_ry;
    logic                     r_eos, n_eos, r_drop, n_drop;

    logic                     ram_we;
    logic [2*VTX_W-1:0]       ram_rdata;
    logic signed [VTX_W-1:0]  rd_x, rd_y;
    logic [TRIG_W-1:0]        phase;
    logic                     quad_neg;
    logic signed [TRIG_W-1:0] xs, ys, atan_v;
    logic signed [DX_W-1:0]   mul_a;
    logic signed [TRIG_W-1:0] mul_b;
    logic signed [ACC_W-FRAC_W-2:0] qx, qy;
    logic                     is_last;

    vsrot_ram #(
        .WIDTH (2 * VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_vertex_x, i_vertex_y}),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*VTX_W-1:VTX_W];
    assign rd_y = ram_rdata[VTX_W-1:0];

    assign busy = (r_state != S_LOAD);

    // Quadrant fold: second and third quadrants rotate by a half turn, negate at the end.
    assign phase    = {r_angle, {(TRIG_W-ANG_W){1'b0}}};
    assign quad_neg = phase[TRIG_W-1] ^ phase[TRIG_W-2];

    assign xs     = r_cx >>> r_step;
    assign ys     = r_cy >>> r_step;
    assign atan_v = atan_phase(ATAN_IDX_W'(r_step));

    always_comb begin
        unique case (r_k)
            3'd0:    begin mul_a = r_dx; mul_b = r_cos; end
            3'd1:    begin mul_a = r_dy; mul_b = r_sin; end
            3'd2:    begin mul_a = r_dx; mul_b = r_sin; end
            default: begin mul_a = r_dy; mul_b = r_cos; end
        endcase
    end

    // Drop the rounding fraction: bits above 2^31 are the result before saturation.
    assign qx = r_accx[ACC_W-1:FRAC_W+1];
    assign qy = r_accy[ACC_W-1:FRAC_W+1];

    assign is_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_min_x    = r_min_x;
        n_min_y    = r_min_y;
        n_max_x    = r_max_x;
        n_max_y    = r_max_y;
        n_angle    = r_angle;
        n_step     = r_step;
        n_k        = r_k;
        n_idx      = r_idx;
        n_strobe   = 1'b0;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_cz       = r_cz;
        n_neg      = r_neg;
        n_cos      = r_cos;
        n_sin      = r_sin;
        n_csx      = r_csx;
        n_csy      = r_csy;
        n_biasx    = r_biasx;
        n_biasy    = r_biasy;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_prod     = r_prod;
        n_accx     = r_accx;
        n_accy     = r_accy;
        n_rx       = r_rx;
        n_ry       = r_ry;
        n_eos      = r_eos;
        n_drop     = r_drop;
        ram_we     = 1'b0;

        if (i_cfg_we) begin
            n_angle = i_cfg_wdata;
        end

        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (r_count < CNT_W'(MAX_VERTICES)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (i_vertex_x < r_min_x) n_min_x = i_vertex_x;
                        if (i_vertex_y < r_min_y) n_min_y = i_vertex_y;
                        if (i_vertex_x > r_max_x) n_max_x = i_vertex_x;
                        if (i_vertex_y > r_max_y) n_max_y = i_vertex_y;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last_vertex) begin
                        n_cx    = CORDIC_GAIN;
                        n_cy    = '0;
                        n_cz    = signed'({phase[TRIG_W-1] ^ quad_neg, phase[TRIG_W-2:0]});
                        n_neg   = quad_neg;
                        n_step  = '0;
                        n_state = S_CORDIC;
                    end
                end
            end
            S_CORDIC: begin
                if (!r_cz[TRIG_W-1]) begin
                    n_cx = r_cx - ys;
                    n_cy = r_cy + xs;
                    n_cz = r_cz - atan_v;
                end else begin
                    n_cx = r_cx + ys;
                    n_cy = r_cy - xs;
                    n_cz = r_cz + atan_v;
                end
                // Doubled box center, settled since the last item was taken.
                n_csx = CS_W'(r_min_x) + CS_W'(r_max_x);
                n_csy = CS_W'(r_min_y) + CS_W'(r_max_y);
                if (r_step == STEP_W'(NSTEPS - 1)) begin
                    n_state = S_SETUP;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_SETUP: begin
                n_cos   = r_neg ? -r_cx : r_cx;
                n_sin   = r_neg ? -r_cy : r_cy;
                n_biasx = (ACC_W'(r_csx) <<< FRAC_W) + (ACC_W'(1) <<< FRAC_W);
                n_biasy = (ACC_W'(r_csy) <<< FRAC_W) + (ACC_W'(1) <<< FRAC_W);
                n_idx   = '0;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_dx    = (DX_W'(rd_x) <<< 1) - DX_W'(r_csx);
                n_dy    = (DX_W'(rd_y) <<< 1) - DX_W'(r_csy);
                n_k     = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                // Product k is formed while product k-1 is summed.
                n_prod = mul_a * mul_b;
                unique case (r_k)
                    3'd0:    ;
                    3'd1:    n_accx = r_biasx + ACC_W'(r_prod);
                    3'd2:    n_accx = r_accx - ACC_W'(r_prod);
                    3'd3:    n_accy = r_biasy + ACC_W'(r_prod);
                    default: n_accy = r_accy + ACC_W'(r_prod);
                endcase
                if (r_k == MUL_LAST) begin
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_EMIT: begin
                if (qx > (ACC_W-FRAC_W-1)'(COORD_MAX)) n_rx = COORD_MAX;
                else if (qx < (ACC_W-FRAC_W-1)'(COORD_MIN)) n_rx = COORD_MIN;
                else n_rx = qx[VTX_W-1:0];
                if (qy > (ACC_W-FRAC_W-1)'(COORD_MAX)) n_ry = COORD_MAX;
                else if (qy < (ACC_W-FRAC_W-1)'(COORD_MIN)) n_ry = COORD_MIN;
                else n_ry = qy[VTX_W-1:0];
                n_strobe = 1'b1;
                n_eos    = is_last;
                n_drop   = r_overflow;
                if (is_last) begin
                    // Clear the set for the next load.
                    n_count    = '0;
                    n_overflow = 1'b0;
                    n_min_x    = BOX_START_MIN;
                    n_min_y    = BOX_START_MIN;
                    n_max_x    = BOX_START_MAX;
                    n_max_y    = BOX_START_MAX;
                    n_state    = S_LOAD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_DIFF;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_min_x    <= BOX_START_MIN;
            r_min_y    <= BOX_START_MIN;
            r_max_x    <= BOX_START_MAX;
            r_max_y    <= BOX_START_MAX;
            r_angle    <= '0;
            r_step     <= '0;
            r_k        <= '0;
            r_idx      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_min_x    <= n_min_x;
            r_min_y    <= n_min_y;
            r_max_x    <= n_max_x;
            r_max_y    <= n_max_y;
            r_angle    <= n_angle;
            r_step     <= n_step;
            r_k        <= n_k;
            r_idx      <= n_idx;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_neg   <= n_neg;
        r_cos   <= n_cos;
        r_sin   <= n_sin;
        r_csx   <= n_csx;
        r_csy   <= n_csy;
        r_biasx <= n_biasx;
        r_biasy <= n_biasy;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_prod  <= n_prod;
        r_accx  <= n_accx;
        r_accy  <= n_accy;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_eos   <= n_eos;
        r_drop  <= n_drop;
    end

    assign o_strobe       = r_strobe;
    assign o_rotated_x    = r_rx;
    assign o_rotated_y    = r_ry;
    assign o_end_of_set   = r_eos;
    assign o_dropped_flag = r_drop;

endmodule

`default_nettype wire
